/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the PSO core. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PSO_ASSERT(lbl, clk_i, rst_ni, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("PSO assertion failed");

// expression must never be true outside reset
`define PSO_ASSERT_NEVER(lbl, clk_i, rst_ni, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("PSO forbidden condition seen");

`else

`define PSO_ASSERT(lbl, clk_i, rst_ni, prop)
`define PSO_ASSERT_NEVER(lbl, clk_i, rst_ni, expr)

`endif

`endif

/* rtl/core/pso_pkg.sv */
// ----------------------------------------------------------------------------
// pso_pkg
// Types, constants and saturating fixed-point helpers for the PSO update core.
// ----------------------------------------------------------------------------
`default_nettype none

package pso_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int RAND_BITS    = 16;
  localparam int WGT_BITS     = 16;
  localparam int CFG_IDX_BITS = 8;
  localparam int PROD_W       = VALUE_BITS + WGT_BITS;
  localparam int NUM_STAGES   = 6;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [RAND_BITS-1:0]         rnd_t;
  typedef logic [WGT_BITS-1:0]          wgt_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // register indexes
  localparam cfg_idx_t REG_MOMENTUM     = CFG_IDX_BITS'(0);
  localparam cfg_idx_t REG_OWN_WEIGHT   = CFG_IDX_BITS'(1);
  localparam cfg_idx_t REG_GUIDE_WEIGHT = CFG_IDX_BITS'(2);
  localparam cfg_idx_t REG_SEARCH_FRAC  = CFG_IDX_BITS'(3);

  // reset values: 1.0, 2.0, 2.0 in Q4.12 and about 0.1 in Q0.16
  localparam wgt_t RST_MOMENTUM     = 16'd4096;
  localparam wgt_t RST_OWN_WEIGHT   = 16'd8192;
  localparam wgt_t RST_GUIDE_WEIGHT = 16'd8192;
  localparam wgt_t RST_SEARCH_FRAC  = 16'd6554;

  localparam logic [4:0] SH_Q12 = 5'd12;
  localparam logic [4:0] SH_Q16 = 5'd16;

  typedef struct packed {
    wgt_t momentum;
    wgt_t own_weight;
    wgt_t guide_weight;
    wgt_t search_fraction;
  } cfg_t;

  function automatic val_t sat_add(input val_t a, input val_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VALUE_BITS-1:0]);
  endfunction

  function automatic val_t sat_sub(input val_t a, input val_t b);
    logic signed [VALUE_BITS:0] s;
    s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
    if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
      return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
    end
    return val_t'(s[VALUE_BITS-1:0]);
  endfunction

  // (|a| * k) >> sh, truncated on the magnitude, saturated, sign restored
  function automatic val_t mul_shift(input val_t a, input wgt_t k, input logic [4:0] sh);
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     q;
    logic [PROD_W-1:0]     lim;
    logic [PROD_W-1:0]     r;
    logic [VALUE_BITS-1:0] rv;
    neg  = a[VALUE_BITS-1];
    mag  = neg ? unsigned'(-a) : unsigned'(a);
    prod = {{WGT_BITS{1'b0}}, mag} * {{VALUE_BITS{1'b0}}, k};
    q    = prod >> sh;
    lim  = PROD_W'(1) << (VALUE_BITS - 1);
    if (!neg) begin
      lim = lim - PROD_W'(1);
    end
    r  = (q > lim) ? lim : q;
    rv = r[VALUE_BITS-1:0];
    return neg ? val_t'(-rv) : val_t'(rv);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pso_cfg.sv */
// ----------------------------------------------------------------------------
// pso_cfg
// Configuration registers of the PSO update core: weights and search fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module pso_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire pso_pkg::cfg_idx_t cfg_index,
  input  wire pso_pkg::wgt_t    cfg_data,
  output pso_pkg::cfg_t         cfg
);
  import pso_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOMENTUM:     cfg_nxt.momentum        = cfg_data;
        REG_OWN_WEIGHT:   cfg_nxt.own_weight      = cfg_data;
        REG_GUIDE_WEIGHT: cfg_nxt.guide_weight    = cfg_data;
        REG_SEARCH_FRAC:  cfg_nxt.search_fraction = cfg_data;
        default:          cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.momentum        <= RST_MOMENTUM;
      cfg_r.own_weight      <= RST_OWN_WEIGHT;
      cfg_r.guide_weight    <= RST_GUIDE_WEIGHT;
      cfg_r.search_fraction <= RST_SEARCH_FRAC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pso_particle_dimension_update.sv */
// ----------------------------------------------------------------------------
// pso_particle_dimension_update
// One-dimension particle swarm update: weighted velocity, velocity clamp to
// +-search_fraction*range width, position clamp to [range_low, range_high].
//
//   channel | direction | handshake            | payload
//   in_     | request   | in_valid / in_stall  | velocity, position, bests,
//           |           |                      | range bounds, two randoms
//   out_    | result    | out_valid/out_stall  | velocity_out, position_out
//   cfg_    | write     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Six register stages; one request per cycle while in_stall is low. Stage depth
// is set by one 32x16 multiply with saturation. Each stage holds while its
// successor is full and stalled; empty stages fill. Synchronous reset clears
// valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pso_particle_dimension_update (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pso_pkg::val_t     in_velocity_in,
  input  wire pso_pkg::val_t     in_position_in,
  input  wire pso_pkg::val_t     in_own_best,
  input  wire pso_pkg::val_t     in_guide_best,
  input  wire pso_pkg::val_t     in_range_low,
  input  wire pso_pkg::val_t     in_range_high,
  input  wire pso_pkg::rnd_t     in_own_rand,
  input  wire pso_pkg::rnd_t     in_guide_rand,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pso_pkg::val_t          out_velocity_out,
  output pso_pkg::val_t          out_position_out,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire pso_pkg::cfg_idx_t cfg_index,
  input  wire pso_pkg::wgt_t     cfg_data
);
  import pso_pkg::*;

  cfg_t cfg;

  pso_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // stage 1: differences and range width
  val_t s1_d1_r, s1_d2_r, s1_wid_r, s1_v_r, s1_x_r, s1_lo_r, s1_hi_r;
  rnd_t s1_r1_r, s1_r2_r;
  val_t s1_wid_nxt;

  always_comb begin
    s1_wid_nxt = sat_sub(in_range_high, in_range_low);
    if (s1_wid_nxt[VALUE_BITS-1]) begin
      s1_wid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_d1_r  <= sat_sub(in_own_best, in_position_in);
      s1_d2_r  <= sat_sub(in_guide_best, in_position_in);
      s1_wid_r <= s1_wid_nxt;
      s1_v_r   <= in_velocity_in;
      s1_x_r   <= in_position_in;
      s1_lo_r  <= in_range_low;
      s1_hi_r  <= in_range_high;
      s1_r1_r  <= in_own_rand;
      s1_r2_r  <= in_guide_rand;
    end
  end

  // stage 2: weight products and velocity limit
  val_t s2_mv_r, s2_a1_r, s2_a2_r, s2_vmax_r, s2_x_r, s2_lo_r, s2_hi_r;
  rnd_t s2_r1_r, s2_r2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_mv_r   <= mul_shift(s1_v_r, cfg.momentum, SH_Q12);
      s2_a1_r   <= mul_shift(s1_d1_r, cfg.own_weight, SH_Q12);
      s2_a2_r   <= mul_shift(s1_d2_r, cfg.guide_weight, SH_Q12);
      s2_vmax_r <= mul_shift(s1_wid_r, cfg.search_fraction, SH_Q16);
      s2_x_r    <= s1_x_r;
      s2_lo_r   <= s1_lo_r;
      s2_hi_r   <= s1_hi_r;
      s2_r1_r   <= s1_r1_r;
      s2_r2_r   <= s1_r2_r;
    end
  end

  // stage 3: random factors
  val_t s3_mv_r, s3_t1_r, s3_t2_r, s3_vmax_r, s3_x_r, s3_lo_r, s3_hi_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_mv_r   <= s2_mv_r;
      s3_t1_r   <= mul_shift(s2_a1_r, s2_r1_r, SH_Q16);
      s3_t2_r   <= mul_shift(s2_a2_r, s2_r2_r, SH_Q16);
      s3_vmax_r <= s2_vmax_r;
      s3_x_r    <= s2_x_r;
      s3_lo_r   <= s2_lo_r;
      s3_hi_r   <= s2_hi_r;
    end
  end

  // stage 4: momentum plus own term
  val_t s4_sum_r, s4_t2_r, s4_vmax_r, s4_x_r, s4_lo_r, s4_hi_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_sum_r  <= sat_add(s3_mv_r, s3_t1_r);
      s4_t2_r   <= s3_t2_r;
      s4_vmax_r <= s3_vmax_r;
      s4_x_r    <= s3_x_r;
      s4_lo_r   <= s3_lo_r;
      s4_hi_r   <= s3_hi_r;
    end
  end

  // stage 5: guide term and velocity clamp
  val_t s5_nv_r, s5_vmax_r, s5_x_r, s5_lo_r, s5_hi_r;
  val_t s5_nv_nxt;

  always_comb begin
    s5_nv_nxt = sat_add(s4_sum_r, s4_t2_r);
    if (s5_nv_nxt > s4_vmax_r) begin
      s5_nv_nxt = s4_vmax_r;
    end
    if (s5_nv_nxt < -s4_vmax_r) begin
      s5_nv_nxt = -s4_vmax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_nv_r   <= s5_nv_nxt;
      s5_vmax_r <= s4_vmax_r;
      s5_x_r    <= s4_x_r;
      s5_lo_r   <= s4_lo_r;
      s5_hi_r   <= s4_hi_r;
    end
  end

  // stage 6: position update and range clamp
  val_t s6_vel_r, s6_pos_r, s6_lo_r, s6_hi_r;
  val_t s6_pos_nxt;

  always_comb begin
    s6_pos_nxt = sat_add(s5_x_r, s5_nv_r);
    if (s6_pos_nxt > s5_hi_r) begin
      s6_pos_nxt = s5_hi_r;
    end
    if (s6_pos_nxt < s5_lo_r) begin
      s6_pos_nxt = s5_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s6_vel_r <= s5_nv_r;
      s6_pos_r <= s6_pos_nxt;
      s6_lo_r  <= s5_lo_r;
      s6_hi_r  <= s5_hi_r;
    end
  end

  assign out_velocity_out = s6_vel_r;
  assign out_position_out = s6_pos_r;

  `PSO_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> (&vld_r))
  `PSO_ASSERT(a_vel_in_limit, clk, rst_n, vld_r[4] |-> (s5_nv_r <= s5_vmax_r && s5_nv_r >= -s5_vmax_r))
  `PSO_ASSERT(a_pos_in_range, clk, rst_n, (vld_r[5] && s6_lo_r <= s6_hi_r) |-> (s6_pos_r >= s6_lo_r && s6_pos_r <= s6_hi_r))
  `PSO_ASSERT_NEVER(a_no_drop_on_stall, clk, rst_n, vld_r[4] && !rdy[5] && rdy[4])

endmodule

`default_nettype wire

/* tb/pso_particle_dimension_update_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pso_particle_dimension_update_test
// Self-checking bench for the one-dimension swarm update. Requests go in with
// random bursts and gaps, results are stalled on a changing pattern, and every
// result is checked against a fixed-point prediction of velocity and position
// under several weight settings, the extremes among them.
// ----------------------------------------------------------------------------
module pso_particle_dimension_update_test;
  import pso_pkg::*;

  localparam longint VALUE_HI     = 64'sd2147483647;
  localparam longint VALUE_LO     = -64'sd2147483648;
  localparam int     DRAIN_CYCLES = 12;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     PHASE_ITEMS  = 235;
  localparam int     PHASE_COUNT  = 8;

  typedef struct {
    val_t velocity;
    val_t position;
    val_t own_best;
    val_t guide_best;
    val_t range_low;
    val_t range_high;
    rnd_t own_rand;
    rnd_t guide_rand;
  } request_t;

  typedef struct {
    val_t velocity;
    val_t position;
  } move_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class move_scoreboard;
    wgt_t  momentum;
    wgt_t  own_weight;
    wgt_t  guide_weight;
    wgt_t  search_fraction;
    move_t pending_moves[$];
    int    mismatches;

    function new();
      momentum        = RST_MOMENTUM;
      own_weight      = RST_OWN_WEIGHT;
      guide_weight    = RST_GUIDE_WEIGHT;
      search_fraction = RST_SEARCH_FRAC;
      mismatches      = 0;
    endfunction

    function void set_register(cfg_idx_t idx, wgt_t data);
      case (idx)
        REG_MOMENTUM:     momentum = data;
        REG_OWN_WEIGHT:   own_weight = data;
        REG_GUIDE_WEIGHT: guide_weight = data;
        REG_SEARCH_FRAC:  search_fraction = data;
        default: ;
      endcase
    endfunction

    function longint clip_value(longint a);
      if (a > VALUE_HI) return VALUE_HI;
      if (a < VALUE_LO) return VALUE_LO;
      return a;
    endfunction

    // truncates on the magnitude, saturates, restores the sign
    function longint scale_magnitude(longint a, int unsigned k, int unsigned sh);
      longint unsigned mag;
      longint unsigned q;
      longint unsigned lim;
      mag = (a < 0) ? -a : a;
      q   = (mag * k) >> sh;
      lim = (a < 0) ? 64'd2147483648 : 64'd2147483647;
      if (q > lim) q = lim;
      return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function move_t predict_move(request_t r);
      longint v, x, low, high, span, vlimit, pull_own, pull_guide, nv, np;
      move_t  m;
      v    = longint'(r.velocity);
      x    = longint'(r.position);
      low  = longint'(r.range_low);
      high = longint'(r.range_high);
      span = clip_value(high - low);
      if (span < 0) span = 0;
      vlimit = scale_magnitude(span, search_fraction, 16);
      pull_own = scale_magnitude(scale_magnitude(
        clip_value(longint'(r.own_best) - x), own_weight, 12), r.own_rand, 16);
      pull_guide = scale_magnitude(scale_magnitude(
        clip_value(longint'(r.guide_best) - x), guide_weight, 12), r.guide_rand, 16);
      nv = clip_value(clip_value(scale_magnitude(v, momentum, 12) + pull_own) + pull_guide);
      if (nv > vlimit) nv = vlimit;
      if (nv < -vlimit) nv = -vlimit;
      np = clip_value(x + nv);
      if (np > high) np = high;
      if (np < low) np = low;
      m.velocity = val_t'(nv);
      m.position = val_t'(np);
      return m;
    endfunction

    function void flag(string what);
      if (mismatches < 10) $display("%s", what);
      mismatches++;
    endfunction

    function void note_request(request_t r);
      pending_moves.push_back(predict_move(r));
    endfunction

    function void check_result(val_t velocity, val_t position);
      move_t want;
      if (pending_moves.size() == 0) begin
        flag($sformatf("unexpected result: velocity %0d position %0d", velocity, position));
        return;
      end
      want = pending_moves.pop_front();
      if (velocity !== want.velocity)
        flag($sformatf("velocity mismatch: expected %0d actual %0d",
                       want.velocity, velocity));
      if (position !== want.position)
        flag($sformatf("position mismatch: expected %0d actual %0d",
                       want.position, position));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  val_t     in_velocity_in = '0;
  val_t     in_position_in = '0;
  val_t     in_own_best = '0;
  val_t     in_guide_best = '0;
  val_t     in_range_low = '0;
  val_t     in_range_high = '0;
  rnd_t     in_own_rand = '0;
  rnd_t     in_guide_rand = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  val_t     out_velocity_out;
  val_t     out_position_out;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = '0;
  wgt_t     cfg_data = '0;

  move_scoreboard board = new();
  int          cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_tick = 0;

  pso_particle_dimension_update u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_velocity_in   (in_velocity_in),
    .in_position_in   (in_position_in),
    .in_own_best      (in_own_best),
    .in_guide_best    (in_guide_best),
    .in_range_low     (in_range_low),
    .in_range_high    (in_range_high),
    .in_own_rand      (in_own_rand),
    .in_guide_rand    (in_guide_rand),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_velocity_out (out_velocity_out),
    .out_position_out (out_position_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_velocity_out, out_position_out);
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
      stall_left <= $urandom_range(30, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  function automatic val_t fx(int whole);
    return val_t'(whole <<< 16);
  endfunction

  function automatic val_t random_value();
    case ($urandom_range(0, 4))
      0: return val_t'($urandom);
      1: return val_t'($signed($urandom) >>> $urandom_range(0, 31));
      2: begin
        case ($urandom_range(0, 4))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          3: return val_t'(1);
          default: return val_t'(-1);
        endcase
      end
      default: return val_t'($signed($urandom) >>> $urandom_range(8, 20));
    endcase
  endfunction

  function automatic longint span_pick(longint lo, longint hi);
    longint unsigned width;
    width = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % width);
  endfunction

  function automatic request_t random_request();
    request_t r;
    longint   a, b, lo, hi, w;
    int       sh;
    r.own_rand   = rnd_t'($urandom);
    r.guide_rand = rnd_t'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      r.velocity   = random_value();
      r.position   = random_value();
      r.own_best   = random_value();
      r.guide_best = random_value();
      r.range_low  = random_value();
      r.range_high = random_value();
      return r;
    end
    sh = $urandom_range(1, 26);
    a  = longint'($signed($urandom) >>> sh);
    b  = longint'($signed($urandom) >>> sh);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    w  = hi - lo;
    r.range_low  = val_t'(lo);
    r.range_high = val_t'(hi);
    r.position   = val_t'(span_pick(lo, hi));
    r.own_best   = ($urandom_range(0, 7) == 0) ? random_value() : val_t'(span_pick(lo, hi));
    r.guide_best = ($urandom_range(0, 7) == 0) ? random_value() : val_t'(span_pick(lo, hi));
    r.velocity   = val_t'(board.clip_value(span_pick(-w, w)));
    return r;
  endfunction

  function automatic request_t directed_request(int n);
    request_t r;
    r = '{velocity: '0, position: '0, own_best: '0, guide_best: '0,
          range_low: VAL_MIN, range_high: VAL_MAX, own_rand: 16'hFFFF, guide_rand: 16'hFFFF};
    case (n)
      0: r = '{'0, '0, '0, '0, '0, '0, '0, '0};
      1: begin
        r.velocity = VAL_MAX; r.own_best = VAL_MAX; r.guide_best = VAL_MAX;
      end
      2: begin
        r.velocity = VAL_MIN; r.own_best = VAL_MIN; r.guide_best = VAL_MIN;
      end
      3: begin
        r.position = VAL_MIN; r.own_best = VAL_MAX; r.guide_best = VAL_MAX;
      end
      4: begin
        r.position = VAL_MAX; r.own_best = VAL_MIN; r.guide_best = VAL_MIN;
      end
      5: begin
        // inverted range
        r.range_low = fx(100); r.range_high = fx(-100); r.velocity = fx(5);
        r.own_best = fx(50); r.guide_best = fx(-50);
        r.own_rand = 16'h8000; r.guide_rand = 16'h8000;
      end
      6: begin
        r.range_low = fx(3); r.range_high = fx(3); r.position = fx(3); r.velocity = fx(1);
      end
      7: begin
        r.range_low = fx(-10); r.range_high = fx(10); r.position = fx(9);
        r.velocity = fx(5); r.own_best = fx(10); r.guide_best = fx(10);
      end
      8: begin
        r.range_low = fx(-10); r.range_high = fx(10); r.position = fx(-9);
        r.velocity = fx(-5); r.own_best = fx(-10); r.guide_best = fx(-10);
      end
      9: begin
        r.velocity = val_t'(32'sh0000_8000); r.position = val_t'(32'sh0001_4000);
        r.own_best = fx(2); r.guide_best = fx(-3);
        r.range_low = fx(-5); r.range_high = fx(5);
        r.own_rand = 16'h1234; r.guide_rand = 16'hFEDC;
      end
      10: begin
        r.position = VAL_MIN; r.velocity = VAL_MIN;
        r.range_high = val_t'(VAL_MIN + 1); r.own_rand = '0; r.guide_rand = '0;
      end
      default: begin
        r.position = VAL_MAX; r.velocity = VAL_MAX; r.own_rand = '0; r.guide_rand = '0;
      end
    endcase
    return r;
  endfunction

  task automatic send_request(request_t r);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_velocity_in <= r.velocity;
    in_position_in <= r.position;
    in_own_best    <= r.own_best;
    in_guide_best  <= r.guide_best;
    in_range_low   <= r.range_low;
    in_range_high  <= r.range_high;
    in_own_rand    <= r.own_rand;
    in_guide_rand  <= r.guide_rand;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  task automatic pause_requests(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    while (board.pending_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, wgt_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_weights(wgt_t m, wgt_t o, wgt_t g, wgt_t s);
    write_register(REG_MOMENTUM, m);
    write_register(REG_OWN_WEIGHT, o);
    write_register(REG_GUIDE_WEIGHT, g);
    write_register(REG_SEARCH_FRAC, s);
  endtask

  task automatic apply_setting(int p);
    case (p)
      0: write_weights('0, '0, '0, '0);
      1: write_weights(RST_MOMENTUM, RST_OWN_WEIGHT, RST_GUIDE_WEIGHT, RST_SEARCH_FRAC);
      2: write_weights(16'hFFFF, '0, 16'hFFFF, '0);
      3: write_weights('0, 16'hFFFF, '0, 16'hFFFF);
      default: write_weights(wgt_t'($urandom_range(0, 16384)),
                             wgt_t'($urandom_range(0, 16384)),
                             ($urandom_range(0, 3) == 0) ? wgt_t'($urandom)
                                                         : wgt_t'($urandom_range(0, 16384)),
                             wgt_t'($urandom));
    endcase
    // indexes past the register list must be dropped
    if (p % 2 == 1)
      write_register(cfg_idx_t'($urandom_range(REG_SEARCH_FRAC + 1, 255)), wgt_t'($urandom));
  endtask

  task automatic run_phase(int count, int gap_max);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_request(random_request());
      left -= burst;
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0 && left > 0) pause_requests(gap);
    end
    pause_requests(1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < 12; n++) send_request(directed_request(n));
    pause_requests(1);
    settle();
    write_weights(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int n = 0; n < 12; n++) send_request(directed_request(n));
    pause_requests(1);
    settle();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_setting(p);
      run_phase(PHASE_ITEMS, (p % 3 == 0) ? 0 : $urandom_range(2, 8));
      settle();
    end

    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
